>>> rtl/chte_pkg.sv
`timescale 1ns / 1ps

package chte_pkg;

    localparam int KEY_W     = 64;
    localparam int VAL_W     = 32;
    localparam int COUNT_W   = 9;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        action_t            action;
        logic [KEY_W-1:0]   lookup_key;
        logic [VAL_W-1:0]   entry_value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic               key_present;
        logic [VAL_W-1:0]   found_value;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

endpackage

>>> rtl/chained_hash_table_engine.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// req      input      req_valid / req_ready  req_t: action, lookup_key, entry_value
// rsp      output     rsp_valid / rsp_ready  rsp_t: status, key_present, found_value,
//                                            entry_count
//
// For insert, find and delete, when NUM_BUCKETS is a power of two the bucket row is
// read at accept, then compared and written back in S_EXEC once rsp is free.
// Otherwise one shared multiplier folds the key into the bucket index through
// H_FOLD1..H_FOLD3, H_QUOT and H_REM, then the row is read in S_READ. Clear sweeps
// every bucket's fill count to zero. After reset the fill memory is swept over
// every bucket before req_ready. A result waits in rsp; the next transaction is taken and held until rsp frees.

module chained_hash_table_engine
    import chte_pkg::*;
#(
    parameter int NUM_BUCKETS      = 64,
    parameter int SLOTS_PER_BUCKET = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int  DEPTH   = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int  BKT_W   = $clog2(NUM_BUCKETS);
    localparam int  SLOT_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int  FILL_W  = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int  CNT_RAW = $clog2(DEPTH + 1);
    localparam int  CNT_W   = (CNT_RAW > COUNT_W) ? CNT_RAW : COUNT_W;
    localparam bit  IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    localparam int  ACC_W   = 16 + BKT_W + 2;
    localparam int  MUL_W   = ACC_W + 2;
    localparam int  Q_W     = ACC_W - BKT_W + 1;
    localparam int  RCP_SH  = ACC_W + BKT_W;

    localparam logic [BKT_W-1:0]  LAST_BKT  = BKT_W'(NUM_BUCKETS - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SLOTS_PER_BUCKET);

    localparam logic [63:0]      NB_64  = 64'(NUM_BUCKETS);
    localparam logic [MUL_W-1:0] W16    = MUL_W'((64'd1 << 16) % NB_64);
    localparam logic [MUL_W-1:0] W32    = MUL_W'((64'd1 << 32) % NB_64);
    localparam logic [MUL_W-1:0] W48    = MUL_W'((64'd1 << 48) % NB_64);
    localparam logic [MUL_W-1:0] RCP    =
        MUL_W'(((64'd1 << RCP_SH) + NB_64 - 64'd1) / NB_64);
    localparam logic [MUL_W-1:0] NB_MUL = MUL_W'(NUM_BUCKETS);

    typedef logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0] key_row_t;
    typedef logic [SLOTS_PER_BUCKET-1:0][VAL_W-1:0] val_row_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_READ,
        S_EXEC,
        S_CLEAR
    } state_t;

    typedef enum logic [2:0] {
        H_FOLD1,
        H_FOLD2,
        H_FOLD3,
        H_QUOT,
        H_REM
    } hstep_t;

    // Bucket rows and fill counts
    key_row_t          key_mem  [NUM_BUCKETS];
    val_row_t          val_mem  [NUM_BUCKETS];
    logic [FILL_W-1:0] fill_mem [NUM_BUCKETS];

    key_row_t          key_rd;
    val_row_t          val_rd;
    logic [FILL_W-1:0] fill_rd;

    state_t                state_reg, state_next;
    req_t                  req_reg, req_next;
    logic [BKT_W-1:0]      bucket_reg, bucket_next;
    hstep_t                hstep_reg, hstep_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [Q_W-1:0]        q_reg, q_next;
    logic [BKT_W-1:0]      sweep_reg, sweep_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  rd_en;
    logic [BKT_W-1:0]      rd_addr;
    logic                  sweeping;
    logic                  proceed;
    logic                  row_we;
    logic                  fill_upd;
    logic                  fill_we;
    logic [BKT_W-1:0]      fill_addr;
    logic [FILL_W-1:0]     fill_wdata;

    logic [SLOTS_PER_BUCKET-1:0] hit;
    logic                  hit_any;
    logic [SLOT_W-1:0]     hit_slot;
    logic [FILL_W-1:0]     tail_full;
    logic [SLOT_W-1:0]     tail_slot;
    logic                  bucket_full;
    key_row_t              key_wr;
    val_row_t              val_wr;
    logic [FILL_W-1:0]     fill_wr;
    logic [CNT_W-1:0]      cnt_result;
    rsp_t                  result;
    logic                  mod_upd;

    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic [2*MUL_W-1:0]    mul_p;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign sweeping = (state_reg == S_INIT) || (state_reg == S_CLEAR);
    assign proceed  = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

    // Read the row at accept when the bucket is just the low key bits, else in S_READ
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = bucket_reg;
        if (state_reg == S_IDLE)
        begin
            rd_addr = req.lookup_key[BKT_W-1:0];
            rd_en   = IS_POW2 && req_valid && (req.action != ACT_CLEAR);
        end
        else if (state_reg == S_READ)
        begin
            rd_en = 1'b1;
        end
    end

    // Shared multiplier: fold the 16-bit key chunks by 2^16k mod NUM_BUCKETS,
    // then take the remainder of the folded sum through a reciprocal
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (hstep_reg)
            H_FOLD1:
            begin
                mul_a = MUL_W'(req_reg.lookup_key[31:16]);
                mul_b = W16;
            end
            H_FOLD2:
            begin
                mul_a = MUL_W'(req_reg.lookup_key[47:32]);
                mul_b = W32;
            end
            H_FOLD3:
            begin
                mul_a = MUL_W'(req_reg.lookup_key[63:48]);
                mul_b = W48;
            end
            H_QUOT:
            begin
                mul_a = MUL_W'(acc_reg);
                mul_b = RCP;
            end
            H_REM:
            begin
                mul_a = MUL_W'(q_reg);
                mul_b = NB_MUL;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p = (2*MUL_W)'(mul_a) * (2*MUL_W)'(mul_b);

    // Compare all slots of the row at once
    always_comb
    begin
        hit_slot = '0;
        for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--)
        begin
            hit[s] = (FILL_W'(s) < fill_rd) && (key_rd[s] == req_reg.lookup_key);
            if (hit[s])
            begin
                hit_slot = SLOT_W'(s);
            end
        end
    end

    assign hit_any     = |hit;
    assign tail_full   = fill_rd - FILL_W'(1);
    assign tail_slot   = tail_full[SLOT_W-1:0];
    assign bucket_full = (fill_rd == FILL_FULL);

    always_comb
    begin
        key_wr     = key_rd;
        val_wr     = val_rd;
        fill_wr    = fill_rd;
        cnt_result = cnt_reg;
        mod_upd    = 1'b0;
        fill_upd   = 1'b0;
        result             = '0;
        result.status      = ST_DONE;
        result.key_present = hit_any;

        unique case (req_reg.action)
            ACT_INSERT:
            begin
                if (hit_any)
                begin
                    val_wr[hit_slot] = req_reg.entry_value;
                    mod_upd          = 1'b1;
                end
                else if (bucket_full)
                begin
                    result.status = ST_FULL;
                end
                else
                begin
                    key_wr[fill_rd[SLOT_W-1:0]] = req_reg.lookup_key;
                    val_wr[fill_rd[SLOT_W-1:0]] = req_reg.entry_value;
                    fill_wr    = fill_rd + FILL_W'(1);
                    cnt_result = cnt_reg + CNT_W'(1);
                    mod_upd    = 1'b1;
                    fill_upd   = 1'b1;
                end
            end
            ACT_FIND:
            begin
                if (hit_any)
                begin
                    result.found_value = val_rd[hit_slot];
                end
                else
                begin
                    result.status = ST_MISSING;
                end
            end
            ACT_DELETE:
            begin
                if (hit_any)
                begin
                    // Move the tail entry into the freed slot
                    key_wr[hit_slot] = key_rd[tail_slot];
                    val_wr[hit_slot] = val_rd[tail_slot];
                    fill_wr  = tail_full;
                    mod_upd  = 1'b1;
                    fill_upd = 1'b1;
                    if (cnt_reg != '0)
                    begin
                        cnt_result = cnt_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    result.status = ST_MISSING;
                end
            end
            ACT_CLEAR:
            begin
                result.key_present = 1'b0;
                cnt_result         = '0;
            end
        endcase

        result.entry_count = cnt_result[COUNT_W-1:0];
    end

    assign row_we     = proceed && mod_upd;
    assign fill_we    = sweeping || (proceed && fill_upd);
    assign fill_addr  = sweeping ? sweep_reg : bucket_reg;
    assign fill_wdata = sweeping ? '0 : fill_wr;

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            key_mem[bucket_reg] <= key_wr;
            val_mem[bucket_reg] <= val_wr;
        end
        if (rd_en)
        begin
            key_rd <= key_mem[rd_addr];
            val_rd <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_addr] <= fill_wdata;
        end
        if (rd_en)
        begin
            fill_rd <= fill_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        bucket_next    = bucket_reg;
        hstep_next     = hstep_reg;
        acc_next       = acc_reg;
        q_next         = q_reg;
        sweep_next     = sweep_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                sweep_next = sweep_reg + BKT_W'(1);
                if (sweep_reg == LAST_BKT)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    if (req.action == ACT_CLEAR)
                    begin
                        sweep_next = '0;
                        state_next = S_CLEAR;
                    end
                    else if (IS_POW2)
                    begin
                        bucket_next = req.lookup_key[BKT_W-1:0];
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        acc_next   = ACC_W'(req.lookup_key[15:0]);
                        hstep_next = H_FOLD1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                unique case (hstep_reg)
                    H_FOLD1:
                    begin
                        acc_next   = acc_reg + ACC_W'(mul_p);
                        hstep_next = H_FOLD2;
                    end
                    H_FOLD2:
                    begin
                        acc_next   = acc_reg + ACC_W'(mul_p);
                        hstep_next = H_FOLD3;
                    end
                    H_FOLD3:
                    begin
                        acc_next   = acc_reg + ACC_W'(mul_p);
                        hstep_next = H_QUOT;
                    end
                    H_QUOT:
                    begin
                        q_next     = mul_p[RCP_SH +: Q_W];
                        hstep_next = H_REM;
                    end
                    H_REM:
                    begin
                        bucket_next = BKT_W'(acc_reg - ACC_W'(mul_p));
                        hstep_next  = H_FOLD1;
                        state_next  = S_READ;
                    end
                    default:
                    begin
                        hstep_next = H_FOLD1;
                    end
                endcase
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // Hold until the rsp register is free
                if (proceed)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = result;
                    cnt_next       = cnt_result;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                sweep_next = sweep_reg + BKT_W'(1);
                if (sweep_reg == LAST_BKT)
                begin
                    sweep_next = '0;
                    state_next = S_EXEC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            req_reg       <= '0;
            bucket_reg    <= '0;
            hstep_reg     <= H_FOLD1;
            acc_reg       <= '0;
            q_reg         <= '0;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            bucket_reg    <= bucket_next;
            hstep_reg     <= hstep_next;
            acc_reg       <= acc_next;
            q_reg         <= q_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import chte_pkg::*;

    localparam int NB             = 64;
    localparam int SLOTS          = 4;
    localparam int RANDOM_ITEMS   = 750;
    localparam int MAX_GAP        = 13;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_RESULT = 200;
    localparam int PAUSE_AT_ITEM  = 420;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [63:0] ALL_ONES = '1;

    class hash_table_sb;
        logic [KEY_W-1:0] key_mem [NB*SLOTS];
        logic [VAL_W-1:0] val_mem [NB*SLOTS];
        int unsigned      fill [NB];
        int unsigned      total;
        rsp_t             pending_results [$];
        int               errors;
        int               n_req, n_insert, n_full, n_find, n_hit, n_delete, n_clear;

        function new();
            for (int i = 0; i < NB; i++)
            begin
                fill[i] = 0;
            end
            total  = 0;
            errors = 0;
            n_req = 0; n_insert = 0; n_full = 0; n_find = 0;
            n_hit = 0; n_delete = 0; n_clear = 0;
        endfunction

        function rsp_t apply_action(req_t r);
            rsp_t        o;
            int          b;
            int          slot;
            int unsigned last;
            o = '0;
            o.status = ST_DONE;
            if (r.action == ACT_CLEAR)
            begin
                for (int i = 0; i < NB; i++)
                begin
                    fill[i] = 0;
                end
                total = 0;
                n_clear++;
            end
            else
            begin
                b = int'(r.lookup_key % 64'(NB));
                slot = -1;
                for (int s = 0; s < int'(fill[b]); s++)
                begin
                    if (slot < 0 && key_mem[b*SLOTS+s] == r.lookup_key)
                        slot = s;
                end
                o.key_present = (slot >= 0);
                case (r.action)
                    ACT_INSERT:
                    begin
                        n_insert++;
                        if (slot >= 0)
                            val_mem[b*SLOTS+slot] = r.entry_value;
                        else if (fill[b] >= SLOTS)
                        begin
                            o.status = ST_FULL;
                            n_full++;
                        end
                        else
                        begin
                            key_mem[b*SLOTS+fill[b]] = r.lookup_key;
                            val_mem[b*SLOTS+fill[b]] = r.entry_value;
                            fill[b]++;
                            total++;
                        end
                    end
                    ACT_FIND:
                    begin
                        n_find++;
                        if (slot >= 0)
                        begin
                            o.found_value = val_mem[b*SLOTS+slot];
                            n_hit++;
                        end
                        else
                            o.status = ST_MISSING;
                    end
                    default:
                    begin
                        n_delete++;
                        if (slot >= 0)
                        begin
                            // move the bucket's tail entry into the hole
                            last = fill[b] - 1;
                            key_mem[b*SLOTS+slot] = key_mem[b*SLOTS+last];
                            val_mem[b*SLOTS+slot] = val_mem[b*SLOTS+last];
                            fill[b] = last;
                            if (total > 0)
                                total--;
                        end
                        else
                            o.status = ST_MISSING;
                    end
                endcase
            end
            o.entry_count = COUNT_W'(total);
            return o;
        endfunction

        function void note_request(req_t r);
            n_req++;
            pending_results.push_back(apply_action(r));
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0)
            begin
                $error("response with no request outstanding: %h", got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.key_present !== want.key_present)
            begin
                $error("key_present: expected %0d, got %0d", want.key_present, got.key_present);
                errors++;
            end
            if (got.found_value !== want.found_value)
            begin
                $error("found_value: expected %h, got %h", want.found_value, got.found_value);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    hash_table_sb sb = new();
    req_t         stimulus [$];
    logic [63:0]  key_pool [64];
    int           quiet_cycles;
    int           results_seen;

    chained_hash_table_engine #(
        .NUM_BUCKETS(NB),
        .SLOTS_PER_BUCKET(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic req_t mk(action_t a, logic [63:0] k, logic [31:0] v);
        req_t r;
        r.action      = a;
        r.lookup_key  = k;
        r.entry_value = v;
        return r;
    endfunction

    function automatic req_t random_request();
        int          roll;
        int          kind;
        action_t     a;
        logic [63:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            a = ACT_INSERT;
        else if (roll < 70)
            a = ACT_FIND;
        else if (roll < 97)
            a = ACT_DELETE;
        else
            a = ACT_CLEAR;
        kind = $urandom_range(0, 9);
        // mostly a crowded pool of keys so buckets fill and keys repeat
        if (kind < 7)
            k = key_pool[$urandom_range(0, 63)];
        else if (kind < 9)
            k = {$urandom, $urandom};
        else
            k = {$urandom, $urandom} & {32'h0, $urandom_range(0, 255)};
        return mk(a, k, $urandom);
    endfunction

    task automatic send_item(req_t item, int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // response side
    initial
    begin
        int gap;
        rsp_ready    = 1'b0;
        results_seen = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (results_seen == HOLD_AT_RESULT)
                gap = LONG_HOLD;
            else if ((results_seen / 60) % 4 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            results_seen++;
            @(negedge clk);
        end
    end

    initial
    begin
        int gap;
        req_valid    = 1'b0;
        req          = '0;
        rst_n        = 1'b0;

        for (int i = 0; i < 64; i++)
            key_pool[i] = {$urandom, 26'($urandom), 6'(i % 8)};

        // empty table, extremes of key and value, replace, full bucket,
        // tail move on delete, clear and reuse
        stimulus.push_back(mk(ACT_FIND,   64'd0, 32'd0));
        stimulus.push_back(mk(ACT_DELETE, 64'd0, 32'hffffffff));
        stimulus.push_back(mk(ACT_INSERT, 64'd0, 32'd0));
        stimulus.push_back(mk(ACT_INSERT, ALL_ONES, 32'hffffffff));
        stimulus.push_back(mk(ACT_FIND,   ALL_ONES, 32'd0));
        stimulus.push_back(mk(ACT_INSERT, 64'd0, 32'h12345678));
        stimulus.push_back(mk(ACT_FIND,   64'd0, 32'd0));
        stimulus.push_back(mk(ACT_INSERT, 64'd64, 32'h00000040));
        stimulus.push_back(mk(ACT_INSERT, 64'd128, 32'h00000080));
        stimulus.push_back(mk(ACT_INSERT, 64'd192, 32'h000000c0));
        stimulus.push_back(mk(ACT_INSERT, 64'd256, 32'h00000100));
        stimulus.push_back(mk(ACT_INSERT, 64'd128, 32'hdeadbeef));
        stimulus.push_back(mk(ACT_DELETE, 64'd64, 32'd0));
        stimulus.push_back(mk(ACT_FIND,   64'd192, 32'd0));
        stimulus.push_back(mk(ACT_FIND,   64'd64, 32'd0));
        stimulus.push_back(mk(ACT_DELETE, 64'd0, 32'd0));
        stimulus.push_back(mk(ACT_FIND,   64'd128, 32'd0));
        stimulus.push_back(mk(ACT_INSERT, 64'haaaaaaaaaaaaaaaa, 32'h55555555));
        stimulus.push_back(mk(ACT_INSERT, 64'h5555555555555555, 32'haaaaaaaa));
        stimulus.push_back(mk(ACT_FIND,   64'h5555555555555555, 32'd0));
        stimulus.push_back(mk(ACT_CLEAR,  64'd0, 32'd0));
        stimulus.push_back(mk(ACT_FIND,   ALL_ONES, 32'd0));
        stimulus.push_back(mk(ACT_INSERT, 64'd0, 32'hffffffff));
        stimulus.push_back(mk(ACT_CLEAR,  ALL_ONES, 32'hffffffff));
        for (int i = 0; i < RANDOM_ITEMS; i++)
            stimulus.push_back(random_request());

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int idx = 0; idx < stimulus.size(); idx++)
        begin
            // drop valid and hold off until the table has answered everything sent so far
            if (idx == PAUSE_AT_ITEM)
            begin
                req_valid <= 1'b0;
                @(negedge clk);
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            if ((idx / 50) % 4 == 3)
                gap = 0;
            else
                gap = $urandom_range(0, MAX_GAP);
            send_item(stimulus[idx], gap);
        end
        req_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (NB + 16) @(posedge clk);
        if (sb.pending() != 0)
            sb.errors++;

        $display("Covered %0d requests: %0d inserts (%0d into full buckets), %0d finds (%0d hits)",
                 sb.n_req, sb.n_insert, sb.n_full, sb.n_find, sb.n_hit);
        $display("  plus %0d deletes and %0d clears, with long output stalls and input pauses",
                 sb.n_delete, sb.n_clear);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
rtl/chte_pkg.sv
rtl/chained_hash_table_engine.sv
tb/tb.sv
